// ===== hw/rtl/dual_axis_pid_pwm_tracker_core_defines.svh =====
// Assertion macros shared by the tracker RTL.
// No dependencies; modules that assert take this file by include.
`ifndef DUAL_AXIS_PID_PWM_TRACKER_CORE_DEFINES_SVH
`define DUAL_AXIS_PID_PWM_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication on the module's clk, quiet while rst is high.
`define DAPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication on the module's clk, quiet while rst is high.
`define DAPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/dapt_pkg.sv =====
// Types, widths, reset values and register indexes for the two-axis PID tracker.
// No dependencies; imported by dual_axis_pid_pwm_tracker_core.
package dapt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DRIVE_W   = 32;
  localparam int EL_W      = 16;
  localparam int GAIN_W    = 24;
  localparam int LIMIT_W   = 26;
  localparam int PWM_W     = 12;
  localparam int ACC_W     = PWM_W + FRAC_BITS;
  localparam int INTEG_W   = 27;
  localparam int CFG_W     = 26;
  localparam int CFG_IDX_W = 3;
  localparam int DEADBAND  = 3;

  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic [LIMIT_W-1:0]         limit_t;
  typedef logic [PWM_W-1:0]           pwm_t;
  typedef logic [ACC_W-1:0]           acc_t;
  typedef logic signed [INTEG_W-1:0]  integ_t;
  typedef logic signed [DRIVE_W-1:0]  drive_t;

  localparam drive_t DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
  localparam drive_t DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

  // Register reset values
  localparam gain_t  GAIN_PROP_RST   = gain_t'(7864);
  localparam gain_t  GAIN_INTEG_RST  = gain_t'(721);
  localparam gain_t  GAIN_DERIV_RST  = gain_t'(2949);
  localparam limit_t INTEG_LIMIT_RST = limit_t'(42598400);
  localparam pwm_t   PWM_LOW_X_RST   = pwm_t'(1565);
  localparam pwm_t   PWM_HIGH_X_RST  = pwm_t'(2520);
  localparam pwm_t   PWM_LOW_Y_RST   = pwm_t'(1355);
  localparam pwm_t   PWM_HIGH_Y_RST  = pwm_t'(2520);
  localparam pwm_t   PWM_CENTER_X    = pwm_t'(2042);
  localparam pwm_t   PWM_CENTER_Y    = pwm_t'(1938);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_PWM_LOW_X   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_PWM_HIGH_X  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_PWM_LOW_Y   = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_PWM_HIGH_Y  = CFG_IDX_W'(7);

endpackage

// ===== hw/rtl/dual_axis_pid_pwm_tracker_core.sv =====
// Two-axis PID tracker with deadband, anti-windup and clamped PWM accumulators.
// Depends on dapt_pkg and dual_axis_pid_pwm_tracker_core_defines.svh.
//
// Usage:
//   Input channel (in_valid / in_stall): one item carries aim and spot
//   coordinates for both axes and the elapsed time. in_stall is high while
//   an item is being worked on; an item is taken when in_valid is high and
//   in_stall is low.
//   Output channel (out_valid / out_stall): one result item per input item
//   with the drive values and the integer PWM positions of both axes.
//   Processing is shortest when both derivative terms are skipped or
//   saturate early and longest when both axes run the full divide. in_stall
//   falls when the result is written to the output register, so the next
//   item can be taken then; the block works on one item at a time. The time
//   taken is set by the restoring divider of the derivative term (one quotient
//   bit per cycle, 32 bits per axis) and by the single 25x27 multiplier that
//   every product of both axes goes through in turn.
//   Stall: a finished result sits in the output register while out_stall is
//   high; the next item is accepted meanwhile and runs until it needs the
//   output register, then waits for it.
//   Reset (rst, synchronous): registers return to defaults, integrals and
//   last errors clear, PWM accumulators return to their center values.
//   Configuration writes (cfg_we) are only allowed while the block is idle.
module dual_axis_pid_pwm_tracker_core
  import dapt_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] aim_x,
  input  logic [COORD_BITS-1:0] aim_y,
  input  logic [COORD_BITS-1:0] spot_x,
  input  logic [COORD_BITS-1:0] spot_y,
  input  logic [EL_W-1:0]       elapsed,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [DRIVE_W-1:0] drive_x,
  output logic signed [DRIVE_W-1:0] drive_y,
  output logic [PWM_W-1:0]      pwm_out_x,
  output logic [PWM_W-1:0]      pwm_out_y
);

  `include "dual_axis_pid_pwm_tracker_core_defines.svh"

  // Widths that follow from the coordinate width
  localparam int ERR_W      = COORD_BITS + 1;
  localparam int DE_W       = COORD_BITS + 2;
  localparam int DMAG_W     = COORD_BITS + 1;
  localparam int MUL_A_W    = GAIN_W + 1;
  localparam int MUL_B_W    = INTEG_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int P_W        = GAIN_W + ERR_W;
  localparam int I_W        = PROD_W - FRAC_BITS;
  localparam int ES_W       = EL_W + ERR_W;
  localparam int ISUM_W     = ((ES_W > INTEG_W) ? ES_W : INTEG_W) + 1;
  localparam int MAG_W      = GAIN_W + DMAG_W;
  localparam int MAG_LO_W   = DRIVE_W - FRAC_BITS;
  localparam int MAG_HI_W   = MAG_W - MAG_LO_W;
  localparam int D_W        = DRIVE_W + 1;
  localparam int SUM_W      = ((P_W > I_W) ? P_W : I_W) + 2;
  localparam int A_W        = DRIVE_W + 2;
  localparam int DIV_CNT_W  = $clog2(DRIVE_W + 1);

  localparam logic signed [ERR_W-1:0] DB_POS = ERR_W'(DEADBAND);
  localparam logic signed [ERR_W-1:0] DB_NEG = -DB_POS;

  // Sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ERR    = 4'd1;
  localparam logic [3:0] ST_MUL_P  = 4'd2;
  localparam logic [3:0] ST_MUL_E  = 4'd3;
  localparam logic [3:0] ST_INTEG  = 4'd4;
  localparam logic [3:0] ST_MUL_I  = 4'd5;
  localparam logic [3:0] ST_MUL_D  = 4'd6;
  localparam logic [3:0] ST_DIV_GO = 4'd7;
  localparam logic [3:0] ST_DIV    = 4'd8;
  localparam logic [3:0] ST_SUM    = 4'd9;
  localparam logic [3:0] ST_PWM    = 4'd10;
  localparam logic [3:0] ST_DONE   = 4'd11;

  logic [3:0] state;
  logic       axis;     // 0 = x, 1 = y

  // Configuration registers
  gain_t  gain_prop;
  gain_t  gain_integ;
  gain_t  gain_deriv;
  limit_t integ_limit;
  pwm_t   pwm_low  [2];
  pwm_t   pwm_high [2];

  // Captured item
  logic [COORD_BITS-1:0] aim  [2];
  logic [COORD_BITS-1:0] spot [2];
  logic [EL_W-1:0]       el;

  // Per-axis loop state
  integ_t                   integ    [2];
  logic signed [ERR_W-1:0]  last_err [2];
  acc_t                     acc      [2];
  drive_t                   drive    [2];

  // Working registers
  logic signed [ERR_W-1:0]  err;
  logic                     de_neg;
  logic                     de_zero;
  logic [DMAG_W-1:0]        dmag;
  logic signed [PROD_W-1:0] prod;
  logic signed [P_W-1:0]    p_term;
  logic signed [I_W-1:0]    i_term;
  logic [EL_W-1:0]          rem;
  logic [DRIVE_W-1:0]       quo;
  logic                     div_sat;
  logic [DIV_CNT_W-1:0]     div_cnt;

  // ------------------------------------------------------------------
  // Error and deadband
  // ------------------------------------------------------------------
  logic signed [ERR_W-1:0] err_raw;
  logic signed [ERR_W-1:0] err_db;
  logic signed [DE_W-1:0]  de;
  logic signed [DE_W-1:0]  de_inv;
  logic [DMAG_W-1:0]       dmag_next;

  always_comb begin
    err_raw   = $signed({1'b0, aim[axis]}) - $signed({1'b0, spot[axis]});
    err_db    = ((err_raw > DB_NEG) && (err_raw < DB_POS)) ? '0 : err_raw;
    de        = DE_W'(err_db) - DE_W'(last_err[axis]);
    de_inv    = -de;
    dmag_next = de[DE_W-1] ? de_inv[DMAG_W-1:0] : de[DMAG_W-1:0];
  end

  // ------------------------------------------------------------------
  // Shared multiplier: operands picked by state, product registered
  // ------------------------------------------------------------------
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  always_comb begin
    unique case (state)
      ST_MUL_P: begin
        mul_a = {1'b0, gain_prop};
        mul_b = MUL_B_W'(err);
      end
      ST_MUL_E: begin
        mul_a = {{(MUL_A_W-EL_W){1'b0}}, el};
        mul_b = MUL_B_W'(err);
      end
      ST_MUL_I: begin
        mul_a = {1'b0, gain_integ};
        mul_b = integ[axis];
      end
      ST_MUL_D: begin
        mul_a = {1'b0, gain_deriv};
        mul_b = {{(MUL_B_W-DMAG_W){1'b0}}, dmag};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Integral update with symmetric clamp
  // ------------------------------------------------------------------
  integ_t                   lim_s;
  integ_t                   neg_lim_s;
  logic signed [ES_W-1:0]   es_val;
  logic signed [ISUM_W-1:0] isum;
  logic signed [ISUM_W-1:0] lim_ext;
  integ_t                   integ_next;

  always_comb begin
    lim_s     = {1'b0, integ_limit};
    neg_lim_s = -lim_s;
    es_val    = prod[ES_W-1:0];
    isum      = ISUM_W'(integ[axis]) + ISUM_W'(es_val);
    lim_ext   = ISUM_W'(lim_s);
    if (isum > lim_ext) begin
      integ_next = lim_s;
    end else if (isum < -lim_ext) begin
      integ_next = neg_lim_s;
    end else begin
      integ_next = isum[INTEG_W-1:0];
    end
  end

  // ------------------------------------------------------------------
  // Derivative divide: (mag << FRAC_BITS) / el, one bit per cycle
  // ------------------------------------------------------------------
  logic [MAG_W-1:0]    mag;
  logic [MAG_HI_W-1:0] mag_hi;
  logic [EL_W:0]       cand;
  logic [EL_W:0]       cand_sub;
  logic                cand_ge;

  always_comb begin
    mag      = prod[MAG_W-1:0];
    mag_hi   = mag[MAG_W-1:MAG_LO_W];
    cand     = {rem, quo[DRIVE_W-1]};
    cand_ge  = (cand >= {1'b0, el});
    cand_sub = cand - {1'b0, el};
  end

  // ------------------------------------------------------------------
  // Derivative saturation and P + I + D sum
  // ------------------------------------------------------------------
  logic [DRIVE_W-1:0]      d_mag;
  logic signed [D_W-1:0]   d_pos;
  logic signed [D_W-1:0]   d_term;
  logic signed [SUM_W-1:0] sum;
  drive_t                  drive_sat;

  always_comb begin
    // Cap the quotient magnitude at 2^31
    if (div_sat || (quo[DRIVE_W-1] && (|quo[DRIVE_W-2:0]))) begin
      d_mag = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      d_mag = quo;
    end
    d_pos = {1'b0, d_mag};
    if (de_neg) begin
      d_term = -d_pos;
    end else if (d_mag[DRIVE_W-1]) begin
      d_term = D_W'(DRIVE_MAX);
    end else begin
      d_term = d_pos;
    end
    sum = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);
    if (sum > SUM_W'(DRIVE_MAX)) begin
      drive_sat = DRIVE_MAX;
    end else if (sum < SUM_W'(DRIVE_MIN)) begin
      drive_sat = DRIVE_MIN;
    end else begin
      drive_sat = sum[DRIVE_W-1:0];
    end
  end

  // ------------------------------------------------------------------
  // PWM accumulator: high limit first, then low limit
  // ------------------------------------------------------------------
  logic signed [A_W-1:0] acc_sum;
  logic signed [A_W-1:0] acc_top;
  logic signed [A_W-1:0] acc_bot;
  logic signed [A_W-1:0] acc_hi_cl;
  acc_t                  acc_next;

  always_comb begin
    acc_sum   = A_W'($signed({1'b0, acc[axis]})) + A_W'(drive[axis]);
    acc_top   = A_W'({pwm_high[axis], {FRAC_BITS{1'b0}}});
    acc_bot   = A_W'({pwm_low[axis], {FRAC_BITS{1'b0}}});
    acc_hi_cl = (acc_sum > acc_top) ? acc_top : acc_sum;
    acc_next  = (acc_hi_cl < acc_bot) ? acc_bot[ACC_W-1:0] : acc_hi_cl[ACC_W-1:0];
  end

  assign in_stall = (state != ST_IDLE);

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop   <= GAIN_PROP_RST;
      gain_integ  <= GAIN_INTEG_RST;
      gain_deriv  <= GAIN_DERIV_RST;
      integ_limit <= INTEG_LIMIT_RST;
      pwm_low[0]  <= PWM_LOW_X_RST;
      pwm_high[0] <= PWM_HIGH_X_RST;
      pwm_low[1]  <= PWM_LOW_Y_RST;
      pwm_high[1] <= PWM_HIGH_Y_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_PROP:   gain_prop   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_INTEG:  gain_integ  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_DERIV:  gain_deriv  <= cfg_data[GAIN_W-1:0];
        REG_INTEG_LIMIT: integ_limit <= cfg_data[LIMIT_W-1:0];
        REG_PWM_LOW_X:   pwm_low[0]  <= cfg_data[PWM_W-1:0];
        REG_PWM_HIGH_X:  pwm_high[0] <= cfg_data[PWM_W-1:0];
        REG_PWM_LOW_Y:   pwm_low[1]  <= cfg_data[PWM_W-1:0];
        REG_PWM_HIGH_Y:  pwm_high[1] <= cfg_data[PWM_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Product register: free-running
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // ------------------------------------------------------------------
  // Sequencer: x axis, then y axis, then hand the result over
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      axis        <= 1'b0;
      out_valid   <= 1'b0;
      integ[0]    <= '0;
      integ[1]    <= '0;
      last_err[0] <= '0;
      last_err[1] <= '0;
      acc[0]      <= {PWM_CENTER_X, {FRAC_BITS{1'b0}}};
      acc[1]      <= {PWM_CENTER_Y, {FRAC_BITS{1'b0}}};
    end else begin
      // drop the result once taken, unless the next one replaces it now
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            aim[0]  <= aim_x;
            aim[1]  <= aim_y;
            spot[0] <= spot_x;
            spot[1] <= spot_y;
            el      <= elapsed;
            axis    <= 1'b0;
            state   <= ST_ERR;
          end
        end
        ST_ERR: begin
          err     <= err_db;
          dmag    <= dmag_next;
          de_neg  <= de[DE_W-1];
          de_zero <= (de == '0);
          state   <= ST_MUL_P;
        end
        ST_MUL_P: begin
          state <= ST_MUL_E;
        end
        ST_MUL_E: begin
          p_term <= prod[P_W-1:0];
          state  <= ST_INTEG;
        end
        ST_INTEG: begin
          integ[axis] <= integ_next;
          state       <= ST_MUL_I;
        end
        ST_MUL_I: begin
          state <= ST_MUL_D;
        end
        ST_MUL_D: begin
          // floor division by 2^FRAC_BITS is the upper slice
          i_term <= prod[PROD_W-1:FRAC_BITS];
          state  <= ST_DIV_GO;
        end
        ST_DIV_GO: begin
          if ((el == '0) || de_zero) begin
            // skip the derivative term
            quo     <= '0;
            div_sat <= 1'b0;
            state   <= ST_SUM;
          end else if (mag_hi >= MAG_HI_W'(el)) begin
            // quotient reaches 2^32: saturate without dividing
            div_sat <= 1'b1;
            state   <= ST_SUM;
          end else begin
            div_sat <= 1'b0;
            rem     <= mag_hi[EL_W-1:0];
            quo     <= {mag[MAG_LO_W-1:0], {FRAC_BITS{1'b0}}};
            div_cnt <= DIV_CNT_W'(DRIVE_W);
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem     <= cand_ge ? cand_sub[EL_W-1:0] : cand[EL_W-1:0];
          quo     <= {quo[DRIVE_W-2:0], cand_ge};
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == DIV_CNT_W'(1)) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          drive[axis] <= drive_sat;
          state       <= ST_PWM;
        end
        ST_PWM: begin
          acc[axis]      <= acc_next;
          last_err[axis] <= err;
          if (!axis) begin
            axis  <= 1'b1;
            state <= ST_ERR;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            drive_x   <= drive[0];
            drive_y   <= drive[1];
            pwm_out_x <= acc[0][ACC_W-1:FRAC_BITS];
            pwm_out_y <= acc[1][ACC_W-1:FRAC_BITS];
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  `DAPT_ASSERT_NEXT(a_accept_starts_x, in_valid && !in_stall, (state == ST_ERR) && !axis, "accepted item did not start on the x axis")
  `DAPT_ASSERT_IMPL(a_div_cnt_live, state == ST_DIV, div_cnt != '0, "divider running with an exhausted count")
  `DAPT_ASSERT_IMPL(a_out_from_done, $rose(out_valid), $past(state) == ST_DONE, "result raised outside the hand-over step")
  `DAPT_ASSERT_IMPL(a_integ_clamped, state == ST_MUL_I, (integ[axis] <= lim_s) && (integ[axis] >= neg_lim_s), "integral outside its clamp")
  `DAPT_ASSERT_IMPL(a_done_after_y, state == ST_DONE, axis, "hand-over reached before the y axis ran")

endmodule
